[sv/kcp_pkg.sv]
`timescale 1ns / 1ps
package kcp_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int MAX_EDGES    = 8192;

    localparam int VW  = $clog2(MAX_VERTICES);      // vertex id
    localparam int NW  = VW + 1;                    // vertex count
    localparam int EW  = $clog2(MAX_EDGES) + 1;     // edge count, degree
    localparam int EAW = $clog2(MAX_EDGES);         // edge buffer address
    localparam int PW  = EW + 1;                    // adjacency pointer
    localparam int JAW = PW - 1;                    // adjacency address
    localparam int BW  = NW;                        // bucket start value

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_REPLY  = 1'b1;

    typedef struct packed {
        logic          opcode;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
        logic          last_edge;
    } t_cmd;

    typedef struct packed {
        logic          result_kind;
        logic [VW-1:0] vertex_id;
        logic [EW-1:0] core_number;
        logic [NW-1:0] vertex_count;
        logic [PW-1:0] trav_count;
        logic          edge_overflow;
    } t_result;

    typedef enum logic [31:0] {
        S_IDLE    = 32'h0000_0001,
        S_READ    = 32'h0000_0002,
        S_CLR     = 32'h0000_0004,
        S_EDGE_RD = 32'h0000_0008,
        S_EDGE_A  = 32'h0000_0010,
        S_EDGE_DA = 32'h0000_0020,
        S_EDGE_DB = 32'h0000_0040,
        S_PFX_RD  = 32'h0000_0080,
        S_PFX_W   = 32'h0000_0100,
        S_BCLR    = 32'h0000_0200,
        S_BCNT_RD = 32'h0000_0400,
        S_BCNT_B  = 32'h0000_0800,
        S_BCNT_W  = 32'h0000_1000,
        S_BPFX_RD = 32'h0000_2000,
        S_BPFX_W  = 32'h0000_4000,
        S_PLC_RD  = 32'h0000_8000,
        S_PLC_B   = 32'h0001_0000,
        S_PLC_W   = 32'h0002_0000,
        S_SHF_RD  = 32'h0004_0000,
        S_SHF_W   = 32'h0008_0000,
        S_PEEL_SV = 32'h0010_0000,
        S_PEEL_V  = 32'h0020_0000,
        S_PEEL_D  = 32'h0040_0000,
        S_PEEL_E  = 32'h0080_0000,
        S_PEEL_J  = 32'h0100_0000,
        S_PEEL_U  = 32'h0200_0000,
        S_PEEL_DU = 32'h0400_0000,
        S_PEEL_P  = 32'h0800_0000,
        S_PEEL_W  = 32'h1000_0000,
        S_PEEL_X  = 32'h2000_0000,
        S_PEEL_B  = 32'h4000_0000,
        S_REPORT  = 32'h8000_0000
    } t_state;

endpackage

[sv/kcp_if.sv]
`timescale 1ns / 1ps
interface kcp_in_if;
    import kcp_pkg::*;
    logic          valid;
    logic          ready;
    logic          opcode;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
    logic          last_edge;
    modport source (output valid, opcode, vertex_a, vertex_b, last_edge, input ready);
    modport sink   (input valid, opcode, vertex_a, vertex_b, last_edge, output ready);
endinterface

interface kcp_out_if;
    import kcp_pkg::*;
    logic          valid;
    logic          ready;
    logic          result_kind;
    logic [VW-1:0] vertex_id;
    logic [EW-1:0] core_number;
    logic [NW-1:0] vertex_count;
    logic [PW-1:0] trav_count;
    logic          edge_overflow;
    modport source (output valid, result_kind, vertex_id, core_number, vertex_count,
                    trav_count, edge_overflow, input ready);
    modport sink   (input valid, result_kind, vertex_id, core_number, vertex_count,
                    trav_count, edge_overflow, output ready);
endinterface

[sv/kcore_peeling_engine.sv]
`timescale 1ns / 1ps
// Edge add: no result unless it carries the last-edge mark; without it the engine stays idle.
// Read: core RAM read, reply then registered; next word accepted once the reply leaves.
// Last edge: degrees, adjacency lists and degree buckets are built, then the peel reads
// each adjacency entry, with a memory read-modify-write where needed, before the report.
// Reset (synchronous, active low) clears counters, flags and the output valid;
// memories hold no reset value and are rebuilt on each run.
module kcore_peeling_engine (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kcp_in_if.sink   i_in,
    kcp_out_if.source o_out
);
    import kcp_pkg::*;

    t_cmd    w_cmd;
    t_result w_res, r_res;
    logic    w_idle, w_res_valid, w_fire, r_ovalid;

    assign w_cmd.opcode    = i_in.opcode;
    assign w_cmd.vertex_a  = i_in.vertex_a;
    assign w_cmd.vertex_b  = i_in.vertex_b;
    assign w_cmd.last_edge = i_in.last_edge;

    assign i_in.ready = w_idle && !r_ovalid;
    assign w_fire     = i_in.valid && i_in.ready;

    kcp_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_fire),
        .i_cmd      (w_cmd),
        .o_idle     (w_idle),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_valid) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.result_kind   = r_res.result_kind;
    assign o_out.vertex_id     = r_res.vertex_id;
    assign o_out.core_number   = r_res.core_number;
    assign o_out.vertex_count  = r_res.vertex_count;
    assign o_out.trav_count    = r_res.trav_count;
    assign o_out.edge_overflow = r_res.edge_overflow;
endmodule

[sv/kcp_ram.sv]
`timescale 1ns / 1ps
module kcp_ram #(
    parameter int AW    = 12,
    parameter int DW    = 12,
    parameter int DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/kcp_engine.sv]
`timescale 1ns / 1ps
module kcp_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  kcp_pkg::t_cmd    i_cmd,
    output logic             o_idle,
    output logic             o_res_valid,
    output kcp_pkg::t_result o_res
);
    import kcp_pkg::*;

    t_state r_state, n_state;
    logic [EW-1:0] r_et, n_et;
    logic [VW-1:0] r_hi, n_hi;
    logic          r_ov, n_ov, r_done, n_done, r_pass, n_pass;
    logic [PW-1:0] r_trav, n_trav, r_acc, n_acc, r_j, n_j, r_jend, n_jend;
    logic [EW-1:0] r_i, n_i, r_maxd, n_maxd, r_dv, n_dv, r_du, n_du;
    logic [VW-1:0] r_a, n_a, r_b, n_b, r_v, n_v, r_u, n_u;
    logic [VW-1:0] r_pu, n_pu, r_pw, n_pw, r_w, n_w;

    logic            eb_we;  logic [EAW-1:0] eb_wa, eb_ra;  logic [2*VW-1:0] eb_wd, eb_rd;
    logic            dg_we;  logic [VW-1:0]  dg_wa, dg_ra;  logic [EW-1:0]   dg_wd, dg_rd;
    logic            fp_we;  logic [VW-1:0]  fp_wa, fp_ra;  logic [PW-1:0]   fp_wd, fp_rd;
    logic            as_we;  logic [NW-1:0]  as_wa, as_ra;  logic [PW-1:0]   as_wd, as_rd;
    logic            aj_we;  logic [JAW-1:0] aj_wa, aj_ra;  logic [VW-1:0]   aj_wd, aj_rd;
    logic            bk_we;  logic [EW-1:0]  bk_wa, bk_ra;  logic [BW-1:0]   bk_wd, bk_rd;
    logic            vs_we;  logic [VW-1:0]  vs_wa, vs_ra;  logic [VW-1:0]   vs_wd, vs_rd;
    logic            sv_we;  logic [VW-1:0]  sv_wa, sv_ra;  logic [VW-1:0]   sv_wd, sv_rd;
    logic            cr_we;  logic [VW-1:0]  cr_wa, cr_ra;  logic [EW-1:0]   cr_wd, cr_rd;

    kcp_ram #(.AW(EAW), .DW(2*VW), .DEPTH(MAX_EDGES)) u_ebuf (.i_clk(i_clk),
        .i_we(eb_we), .i_waddr(eb_wa), .i_wdata(eb_wd), .i_raddr(eb_ra), .o_rdata(eb_rd));
    kcp_ram #(.AW(VW), .DW(EW), .DEPTH(MAX_VERTICES)) u_deg (.i_clk(i_clk),
        .i_we(dg_we), .i_waddr(dg_wa), .i_wdata(dg_wd), .i_raddr(dg_ra), .o_rdata(dg_rd));
    kcp_ram #(.AW(VW), .DW(PW), .DEPTH(MAX_VERTICES)) u_fill (.i_clk(i_clk),
        .i_we(fp_we), .i_waddr(fp_wa), .i_wdata(fp_wd), .i_raddr(fp_ra), .o_rdata(fp_rd));
    kcp_ram #(.AW(NW), .DW(PW), .DEPTH(MAX_VERTICES + 1)) u_astart (.i_clk(i_clk),
        .i_we(as_we), .i_waddr(as_wa), .i_wdata(as_wd), .i_raddr(as_ra), .o_rdata(as_rd));
    kcp_ram #(.AW(JAW), .DW(VW), .DEPTH(2 * MAX_EDGES)) u_adj (.i_clk(i_clk),
        .i_we(aj_we), .i_waddr(aj_wa), .i_wdata(aj_wd), .i_raddr(aj_ra), .o_rdata(aj_rd));
    kcp_ram #(.AW(EW), .DW(BW), .DEPTH(MAX_EDGES + 1)) u_bucket (.i_clk(i_clk),
        .i_we(bk_we), .i_waddr(bk_wa), .i_wdata(bk_wd), .i_raddr(bk_ra), .o_rdata(bk_rd));
    kcp_ram #(.AW(VW), .DW(VW), .DEPTH(MAX_VERTICES)) u_vslot (.i_clk(i_clk),
        .i_we(vs_we), .i_waddr(vs_wa), .i_wdata(vs_wd), .i_raddr(vs_ra), .o_rdata(vs_rd));
    kcp_ram #(.AW(VW), .DW(VW), .DEPTH(MAX_VERTICES)) u_svert (.i_clk(i_clk),
        .i_we(sv_we), .i_waddr(sv_wa), .i_wdata(sv_wd), .i_raddr(sv_ra), .o_rdata(sv_rd));
    kcp_ram #(.AW(VW), .DW(EW), .DEPTH(MAX_VERTICES)) u_core (.i_clk(i_clk),
        .i_we(cr_we), .i_waddr(cr_wa), .i_wdata(cr_wd), .i_raddr(cr_ra), .o_rdata(cr_rd));

    logic [NW-1:0] w_n;
    logic [EW-1:0] w_base_et;
    logic [VW-1:0] w_base_hi, w_hi_a;
    logic          w_last_i;

    assign w_n      = {1'b0, r_hi} + NW'(1);
    assign w_last_i = (r_i[NW-1:0] + NW'(1)) == w_n;
    assign o_idle   = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state; n_et = r_et; n_hi = r_hi; n_ov = r_ov; n_done = r_done;
        n_pass = r_pass; n_trav = r_trav; n_acc = r_acc; n_j = r_j; n_jend = r_jend;
        n_i = r_i; n_maxd = r_maxd; n_dv = r_dv; n_du = r_du; n_a = r_a; n_b = r_b;
        n_v = r_v; n_u = r_u; n_pu = r_pu; n_pw = r_pw; n_w = r_w;
        eb_we = 1'b0; eb_wa = '0; eb_wd = '0; eb_ra = '0;
        dg_we = 1'b0; dg_wa = '0; dg_wd = '0; dg_ra = '0;
        fp_we = 1'b0; fp_wa = '0; fp_wd = '0; fp_ra = '0;
        as_we = 1'b0; as_wa = '0; as_wd = '0; as_ra = '0;
        aj_we = 1'b0; aj_wa = '0; aj_wd = '0; aj_ra = '0;
        bk_we = 1'b0; bk_wa = '0; bk_wd = '0; bk_ra = '0;
        vs_we = 1'b0; vs_wa = '0; vs_wd = '0; vs_ra = '0;
        sv_we = 1'b0; sv_wa = '0; sv_wd = '0; sv_ra = '0;
        cr_we = 1'b0; cr_wa = '0; cr_wd = '0; cr_ra = '0;
        o_res_valid = 1'b0;
        o_res = '0;
        o_res.vertex_count  = w_n;
        o_res.trav_count    = r_trav;
        o_res.edge_overflow = r_ov;
        w_base_et = r_done ? '0 : r_et;
        w_base_hi = r_done ? '0 : r_hi;
        w_hi_a = (i_cmd.vertex_a > w_base_hi) ? i_cmd.vertex_a : w_base_hi;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.opcode == OP_READ) begin
                        cr_ra   = i_cmd.vertex_a;
                        n_a     = i_cmd.vertex_a;
                        n_state = S_READ;
                    end else begin
                        // a finished run is wiped by the next edge
                        n_et = w_base_et; n_hi = w_base_hi;
                        if (r_done) begin
                            n_ov = 1'b0; n_trav = '0; n_done = 1'b0;
                        end
                        if (i_cmd.vertex_a != i_cmd.vertex_b) begin
                            if (w_base_et < EW'(MAX_EDGES)) begin
                                eb_we = 1'b1;
                                eb_wa = w_base_et[EAW-1:0];
                                eb_wd = {i_cmd.vertex_a, i_cmd.vertex_b};
                                n_et  = w_base_et + EW'(1);
                                n_hi  = (i_cmd.vertex_b > w_hi_a) ? i_cmd.vertex_b : w_hi_a;
                            end else begin
                                n_ov = 1'b1;
                            end
                        end
                        if (i_cmd.last_edge) begin
                            n_i = '0;
                            n_state = S_CLR;
                        end
                    end
                end
            end
            S_READ: begin
                o_res_valid = 1'b1;
                o_res.result_kind = KIND_REPLY;
                o_res.vertex_id   = r_a;
                o_res.core_number = (r_done && r_a <= r_hi) ? cr_rd : '0;
                n_state = S_IDLE;
            end
            S_CLR: begin
                dg_we = 1'b1; dg_wa = r_i[VW-1:0];
                if (w_last_i) begin
                    n_i = '0; n_pass = 1'b0; n_maxd = '0;
                    n_state = S_EDGE_RD;
                end else begin
                    n_i = r_i + EW'(1);
                end
            end
            S_EDGE_RD: begin
                if (r_i == r_et) begin
                    n_i = '0;
                    if (!r_pass) begin
                        n_acc = '0;
                        as_we = 1'b1;
                        n_state = S_PFX_RD;
                    end else begin
                        n_state = S_BCLR;
                    end
                end else begin
                    eb_ra = r_i[EAW-1:0];
                    n_state = S_EDGE_A;
                end
            end
            S_EDGE_A: begin
                n_a = eb_rd[2*VW-1:VW];
                n_b = eb_rd[VW-1:0];
                dg_ra = eb_rd[2*VW-1:VW];
                fp_ra = eb_rd[2*VW-1:VW];
                n_state = S_EDGE_DA;
            end
            S_EDGE_DA: begin
                if (!r_pass) begin
                    dg_we = 1'b1; dg_wa = r_a; dg_wd = dg_rd + EW'(1);
                end else begin
                    fp_we = 1'b1; fp_wa = r_a; fp_wd = fp_rd + PW'(1);
                    aj_we = 1'b1; aj_wa = fp_rd[JAW-1:0]; aj_wd = r_b;
                end
                dg_ra = r_b;
                fp_ra = r_b;
                n_state = S_EDGE_DB;
            end
            S_EDGE_DB: begin
                if (!r_pass) begin
                    dg_we = 1'b1; dg_wa = r_b; dg_wd = dg_rd + EW'(1);
                end else begin
                    fp_we = 1'b1; fp_wa = r_b; fp_wd = fp_rd + PW'(1);
                    aj_we = 1'b1; aj_wa = fp_rd[JAW-1:0]; aj_wd = r_a;
                end
                n_i = r_i + EW'(1);
                n_state = S_EDGE_RD;
            end
            S_PFX_RD: begin
                dg_ra = r_i[VW-1:0];
                n_state = S_PFX_W;
            end
            S_PFX_W: begin
                as_we = 1'b1; as_wa = r_i[NW-1:0] + NW'(1); as_wd = r_acc + PW'(dg_rd);
                fp_we = 1'b1; fp_wa = r_i[VW-1:0]; fp_wd = r_acc;
                n_acc = r_acc + PW'(dg_rd);
                if (dg_rd > r_maxd) n_maxd = dg_rd;
                if (w_last_i) begin
                    n_i = '0; n_pass = 1'b1;
                    n_state = S_EDGE_RD;
                end else begin
                    n_i = r_i + EW'(1);
                    n_state = S_PFX_RD;
                end
            end
            S_BCLR: begin
                bk_we = 1'b1; bk_wa = r_i;
                if (r_i == r_maxd) begin
                    n_i = '0;
                    n_state = S_BCNT_RD;
                end else begin
                    n_i = r_i + EW'(1);
                end
            end
            S_BCNT_RD: begin
                dg_ra = r_i[VW-1:0];
                n_state = S_BCNT_B;
            end
            S_BCNT_B: begin
                n_du = dg_rd; bk_ra = dg_rd;
                n_state = S_BCNT_W;
            end
            S_BCNT_W: begin
                bk_we = 1'b1; bk_wa = r_du; bk_wd = bk_rd + BW'(1);
                if (w_last_i) begin
                    n_i = '0; n_acc = '0;
                    n_state = S_BPFX_RD;
                end else begin
                    n_i = r_i + EW'(1);
                    n_state = S_BCNT_RD;
                end
            end
            S_BPFX_RD: begin
                bk_ra = r_i;
                n_state = S_BPFX_W;
            end
            S_BPFX_W: begin
                bk_we = 1'b1; bk_wa = r_i; bk_wd = r_acc[BW-1:0];
                n_acc = r_acc + PW'(bk_rd);
                if (r_i == r_maxd) begin
                    n_i = '0;
                    n_state = S_PLC_RD;
                end else begin
                    n_i = r_i + EW'(1);
                    n_state = S_BPFX_RD;
                end
            end
            S_PLC_RD: begin
                dg_ra = r_i[VW-1:0];
                n_state = S_PLC_B;
            end
            S_PLC_B: begin
                n_du = dg_rd; bk_ra = dg_rd;
                n_state = S_PLC_W;
            end
            S_PLC_W: begin
                vs_we = 1'b1; vs_wa = r_i[VW-1:0]; vs_wd = bk_rd[VW-1:0];
                sv_we = 1'b1; sv_wa = bk_rd[VW-1:0]; sv_wd = r_i[VW-1:0];
                bk_we = 1'b1; bk_wa = r_du; bk_wd = bk_rd + BW'(1);
                if (w_last_i) begin
                    n_i = r_maxd;
                    n_state = S_SHF_RD;
                end else begin
                    n_i = r_i + EW'(1);
                    n_state = S_PLC_RD;
                end
            end
            S_SHF_RD: begin
                // shift bucket starts up one degree, walking down
                if (r_i == '0) begin
                    bk_we = 1'b1;
                    n_trav = '0;
                    n_state = S_PEEL_SV;
                end else begin
                    bk_ra = r_i - EW'(1);
                    n_state = S_SHF_W;
                end
            end
            S_SHF_W: begin
                bk_we = 1'b1; bk_wa = r_i; bk_wd = bk_rd;
                n_i = r_i - EW'(1);
                n_state = S_SHF_RD;
            end
            S_PEEL_SV: begin
                sv_ra = r_i[VW-1:0];
                n_state = S_PEEL_V;
            end
            S_PEEL_V: begin
                n_v = sv_rd; dg_ra = sv_rd; as_ra = {1'b0, sv_rd};
                n_state = S_PEEL_D;
            end
            S_PEEL_D: begin
                n_dv = dg_rd; n_j = as_rd;
                cr_we = 1'b1; cr_wa = r_v; cr_wd = dg_rd;
                as_ra = {1'b0, r_v} + NW'(1);
                n_state = S_PEEL_E;
            end
            S_PEEL_E: begin
                n_jend = as_rd;
                n_state = S_PEEL_J;
            end
            S_PEEL_J: begin
                if (r_j == r_jend) begin
                    if (w_last_i) begin
                        n_state = S_REPORT;
                    end else begin
                        n_i = r_i + EW'(1);
                        n_state = S_PEEL_SV;
                    end
                end else begin
                    aj_ra = r_j[JAW-1:0];
                    n_state = S_PEEL_U;
                end
            end
            S_PEEL_U: begin
                n_u = aj_rd; dg_ra = aj_rd;
                n_trav = r_trav + PW'(1);
                n_state = S_PEEL_DU;
            end
            S_PEEL_DU: begin
                if (dg_rd > r_dv) begin
                    n_du = dg_rd; vs_ra = r_u; bk_ra = dg_rd;
                    n_state = S_PEEL_P;
                end else begin
                    n_j = r_j + PW'(1);
                    n_state = S_PEEL_J;
                end
            end
            S_PEEL_P: begin
                n_pu = vs_rd; n_pw = bk_rd[VW-1:0]; sv_ra = bk_rd[VW-1:0];
                n_state = S_PEEL_W;
            end
            S_PEEL_W: begin
                // move u to the front of its bucket
                if (sv_rd != r_u) begin
                    n_w = sv_rd;
                    vs_we = 1'b1; vs_wa = r_u; vs_wd = r_pw;
                    sv_we = 1'b1; sv_wa = r_pu; sv_wd = sv_rd;
                    n_state = S_PEEL_X;
                end else begin
                    n_state = S_PEEL_B;
                end
            end
            S_PEEL_X: begin
                vs_we = 1'b1; vs_wa = r_w; vs_wd = r_pu;
                sv_we = 1'b1; sv_wa = r_pw; sv_wd = r_u;
                n_state = S_PEEL_B;
            end
            S_PEEL_B: begin
                bk_we = 1'b1; bk_wa = r_du; bk_wd = {1'b0, r_pw} + BW'(1);
                dg_we = 1'b1; dg_wa = r_u; dg_wd = r_du - EW'(1);
                n_j = r_j + PW'(1);
                n_state = S_PEEL_J;
            end
            S_REPORT: begin
                o_res_valid = 1'b1;
                o_res.result_kind = KIND_REPORT;
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_et    <= '0;
            r_hi    <= '0;
            r_ov    <= 1'b0;
            r_done  <= 1'b0;
            r_trav  <= '0;
        end else begin
            r_state <= n_state;
            r_et    <= n_et;
            r_hi    <= n_hi;
            r_ov    <= n_ov;
            r_done  <= n_done;
            r_trav  <= n_trav;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass <= n_pass; r_acc <= n_acc; r_j <= n_j; r_jend <= n_jend;
        r_i <= n_i; r_maxd <= n_maxd; r_dv <= n_dv; r_du <= n_du;
        r_a <= n_a; r_b <= n_b; r_v <= n_v; r_u <= n_u;
        r_pu <= n_pu; r_pw <= n_pw; r_w <= n_w;
    end
endmodule

[tb/sv/kcp_checker.sv]
`timescale 1ns / 1ps
module kcp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kcp_in_if           i_in,
    kcp_out_if          i_out,
    output int          o_errors,
    output int          o_pending,
    output logic        o_moved,
    output int          o_reports,
    output int          o_replies
);
    import kcp_pkg::*;

    // shadow of the engine's graph state
    int unsigned ebuf_a [MAX_EDGES];
    int unsigned ebuf_b [MAX_EDGES];
    int unsigned n_edges;
    int unsigned top_vertex;
    int unsigned degree [MAX_VERTICES];
    int unsigned adj_base [MAX_VERTICES + 1];
    int unsigned adj_ent [2 * MAX_EDGES];
    int unsigned fill_pos [MAX_VERTICES];
    int unsigned cur_deg [MAX_VERTICES];
    int unsigned bkt [MAX_EDGES + 1];
    int unsigned pos_of [MAX_VERTICES];
    int unsigned at_pos [MAX_VERTICES];
    int unsigned coreness [MAX_VERTICES];
    bit          peeled;
    bit          dropped;
    int unsigned visits;

    t_result expected_q[$];
    int      errors;
    int      reports;
    int      replies;

    assign o_errors  = errors;
    assign o_pending = expected_q.size();
    assign o_moved   = (i_in.valid && i_in.ready) || (i_out.valid && i_out.ready);
    assign o_reports = reports;
    assign o_replies = replies;

    task automatic wipe_graph();
        n_edges = 0;
        top_vertex = 0;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            degree[v] = 0;
            fill_pos[v] = 0;
            coreness[v] = 0;
        end
        peeled = 0;
        dropped = 0;
        visits = 0;
    endtask

    task automatic peel_graph();
        int unsigned n, maxd, acc, cnt, v, u, w, du, pu, pw;
        n = top_vertex + 1;
        maxd = 0;
        adj_base[0] = 0;
        for (int i = 0; i < n; i++) adj_base[i + 1] = adj_base[i] + degree[i];
        for (int i = 0; i < MAX_VERTICES; i++) fill_pos[i] = 0;
        for (int i = 0; i < n_edges; i++) begin
            adj_ent[adj_base[ebuf_a[i]] + fill_pos[ebuf_a[i]]] = ebuf_b[i];
            fill_pos[ebuf_a[i]]++;
            adj_ent[adj_base[ebuf_b[i]] + fill_pos[ebuf_b[i]]] = ebuf_a[i];
            fill_pos[ebuf_b[i]]++;
        end
        for (int i = 0; i < n; i++) begin
            cur_deg[i] = degree[i];
            if (cur_deg[i] > maxd) maxd = cur_deg[i];
        end
        for (int d = 0; d <= maxd; d++) bkt[d] = 0;
        for (int i = 0; i < n; i++) bkt[cur_deg[i]]++;
        acc = 0;
        for (int d = 0; d <= maxd; d++) begin
            cnt = bkt[d];
            bkt[d] = acc;
            acc += cnt;
        end
        for (int i = 0; i < n; i++) begin
            pos_of[i] = bkt[cur_deg[i]];
            at_pos[pos_of[i]] = i;
            bkt[cur_deg[i]]++;
        end
        for (int d = maxd; d > 0; d--) bkt[d] = bkt[d - 1];
        bkt[0] = 0;
        visits = 0;
        for (int i = 0; i < n; i++) begin
            v = at_pos[i];
            coreness[v] = cur_deg[v];
            for (int j = adj_base[v]; j < adj_base[v + 1]; j++) begin
                u = adj_ent[j];
                visits++;
                if (cur_deg[u] > cur_deg[v]) begin
                    du = cur_deg[u];
                    pu = pos_of[u];
                    pw = bkt[du];
                    w  = at_pos[pw];
                    if (u != w) begin
                        pos_of[u] = pw;
                        pos_of[w] = pu;
                        at_pos[pu] = w;
                        at_pos[pw] = u;
                    end
                    bkt[du]++;
                    cur_deg[u]--;
                end
            end
        end
    endtask

    function automatic t_result make_result(logic kind, int unsigned vid, int unsigned core);
        t_result r;
        r.result_kind   = kind;
        r.vertex_id     = vid[VW-1:0];
        r.core_number   = core[EW-1:0];
        r.vertex_count  = NW'(top_vertex + 1);
        r.trav_count    = visits[PW-1:0];
        r.edge_overflow = dropped;
        return r;
    endfunction

    task automatic take_word(input t_cmd c);
        int unsigned a, b;
        a = c.vertex_a;
        b = c.vertex_b;
        if (c.opcode == OP_READ) begin
            expected_q.push_back(make_result(KIND_REPLY, a, coreness[a]));
        end else begin
            if (peeled) wipe_graph();
            if (a != b) begin
                if (n_edges >= MAX_EDGES) begin
                    dropped = 1;
                end else begin
                    ebuf_a[n_edges] = a;
                    ebuf_b[n_edges] = b;
                    n_edges++;
                    degree[a]++;
                    degree[b]++;
                    if (a > top_vertex) top_vertex = a;
                    if (b > top_vertex) top_vertex = b;
                end
            end
            if (c.last_edge) begin
                peel_graph();
                peeled = 1;
                expected_q.push_back(make_result(KIND_REPORT, 0, 0));
            end
        end
    endtask

    task automatic check_word(input t_result got);
        t_result want;
        if (expected_q.size() == 0) begin
            $error("unexpected result word: kind %0d vertex %0d", got.result_kind,
                   got.vertex_id);
            errors++;
        end else begin
            want = expected_q.pop_front();
            if (got.result_kind == KIND_REPORT) reports++;
            else replies++;
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
                errors++;
            end
            if (got.vertex_id !== want.vertex_id) begin
                $error("vertex_id exp %0d got %0d", want.vertex_id, got.vertex_id);
                errors++;
            end
            if (got.core_number !== want.core_number) begin
                $error("core_number exp %0d got %0d", want.core_number, got.core_number);
                errors++;
            end
            if (got.vertex_count !== want.vertex_count) begin
                $error("vertex_count exp %0d got %0d", want.vertex_count, got.vertex_count);
                errors++;
            end
            if (got.trav_count !== want.trav_count) begin
                $error("trav_count exp %0d got %0d", want.trav_count,
                       got.trav_count);
                errors++;
            end
            if (got.edge_overflow !== want.edge_overflow) begin
                $error("edge_overflow exp %0d got %0d", want.edge_overflow,
                       got.edge_overflow);
                errors++;
            end
        end
    endtask

    initial begin
        errors = 0;
        reports = 0;
        replies = 0;
        wipe_graph();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // drain results first: a word taken on this edge cannot answer yet
            if (i_out.valid && i_out.ready)
                check_word('{i_out.result_kind, i_out.vertex_id, i_out.core_number,
                             i_out.vertex_count, i_out.trav_count,
                             i_out.edge_overflow});
            if (i_in.valid && i_in.ready)
                take_word('{i_in.opcode, i_in.vertex_a, i_in.vertex_b, i_in.last_edge});
        end
    end

endmodule

[tb/sv/tb_kcore_peeling_engine.sv]
`timescale 1ns / 1ps
module tb_kcore_peeling_engine;
    import kcp_pkg::*;

    localparam int IDLE_LIMIT = 1500000;
    localparam int RANDOM_WORDS = 1900;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, reports, replies;
    logic moved;
    bit   sending;
    int   idle_cycles;
    int   burst_left;
    int   words_sent;
    int   rx_mode, rx_left;

    kcp_in_if  in_ch ();
    kcp_out_if out_ch ();

    kcore_peeling_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    kcp_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_moved   (moved),
        .o_reports (reports),
        .o_replies (replies)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: switch between always ready, coin flip and long stalls
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(20, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || moved || (!sending && pending == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic put_word(input logic op, input int unsigned a, input int unsigned b,
                            input logic last);
        if (burst_left == 0) begin
            // gap between bursts
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.vertex_a  <= a[VW-1:0];
        in_ch.vertex_b  <= b[VW-1:0];
        in_ch.last_edge <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        words_sent++;
    endtask

    task automatic add_edge(input int unsigned a, input int unsigned b, input logic last);
        put_word(OP_ADD, a, b, last);
    endtask

    // read with random junk in the unused fields
    task automatic read_core(input int unsigned v);
        put_word(OP_READ, v, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_graph();
        int unsigned span, n_e, k, a, b;
        span = ($urandom_range(0, 30) == 0) ? 4096 : $urandom_range(2, 40);
        if ($urandom_range(0, 3) == 0) begin
            // dense clique gives high core numbers
            k = $urandom_range(2, 12);
            for (int i = 0; i < k; i++)
                for (int j = i + 1; j < k; j++) add_edge(i, j, 1'b0);
        end
        n_e = $urandom_range(1, 50);
        for (int i = 0; i < n_e; i++) begin
            a = $urandom_range(0, span - 1);
            b = ($urandom_range(0, 9) == 0) ? a : $urandom_range(0, span - 1);
            if ($urandom_range(0, 15) == 0) read_core($urandom_range(0, 4095));
            add_edge(a, b, i == n_e - 1);
        end
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++)
            read_core(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, span - 1));
    endtask

    initial begin
        i_rst_n = 1'b0;
        sending = 1'b1;
        burst_left = 0;
        words_sent = 0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_ADD;
        in_ch.vertex_a = '0;
        in_ch.vertex_b = '0;
        in_ch.last_edge = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first graph spans every vertex id, so each core entry gets written
        add_edge(0, 4095, 1'b0);
        add_edge(4095, 0, 1'b0);
        add_edge(7, 7, 1'b0);
        add_edge(1, 2, 1'b0);
        add_edge(2, 3, 1'b0);
        add_edge(3, 1, 1'b0);
        add_edge(1, 3, 1'b1);
        read_core(0);
        read_core(4095);
        read_core(1);
        read_core(2000);
        // empty graph: only a self-loop, last mark still peels
        add_edge(5, 5, 1'b1);
        read_core(0);
        read_core(4095);
        // read while loading, then close with a self-loop
        add_edge(10, 11, 1'b0);
        read_core(10);
        add_edge(11, 12, 1'b0);
        add_edge(4095, 4095, 1'b1);
        read_core(11);
        read_core(12);

        while (words_sent < RANDOM_WORDS) random_graph();

        in_ch.valid <= 1'b0;
        sending = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d words; checked %0d decomposition reports and %0d core replies.",
                 words_sent, reports, replies);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
